FILE: rtl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the trapezoid wall span generator
// Field widths, command codes, register map and the divider handshake.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int X_W       = 10;  // screen x, signed
  localparam int H_W       = 12;  // half height, unsigned
  localparam int XTO_W     = 17;  // span end x, signed
  localparam int ROW_W     = 7;   // row fields
  localparam int COL_W     = 4;   // palette index
  localparam int FRAC_BITS = 4;   // fraction bits of the slope accumulator
  localparam int ACC_W     = XTO_W + FRAC_BITS;
  localparam int DVD_W     = X_W + FRAC_BITS;      // |dx| * 16 magnitude
  localparam int SLOPE_W   = DVD_W + 1;            // signed quotient
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  // Command kinds
  localparam logic CMD_BOX  = 1'b0;
  localparam logic CMD_SPAN = 1'b1;

  // Register index of mono_mode (word address bit above the byte offset)
  localparam logic REG_MONO = 1'b0;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [H_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/tws_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_cfg: configuration register bank
// APB-style slave holding the mono_mode bit; zero wait states.
// ----------------------------------------------------------------------------
module tws_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tws_pkg::ADDR_W-1:0]  paddr,
  input  logic [tws_pkg::DATA_W-1:0]  pwdata,
  output logic [tws_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic                        mono_mode
);

  logic mono_r;
  logic mono_nxt;
  logic hit_mono;

  assign hit_mono = (paddr[tws_pkg::ADDR_W-1] == tws_pkg::REG_MONO);
  assign pready   = 1'b1;

  always_comb begin
    mono_nxt = mono_r;
    if (psel && penable && pwrite && pready && hit_mono) begin
      mono_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r <= 1'b0;
    end else begin
      mono_r <= mono_nxt;
    end
  end

  assign prdata    = hit_mono ? {{(tws_pkg::DATA_W-1){1'b0}}, mono_r} : '0;
  assign mono_mode = mono_r;

endmodule

FILE: rtl/tws_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_div: serial restoring divider
// Unsigned magnitude division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tws_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tws_pkg::div_req_t req,
  output tws_pkg::div_rsp_t rsp
);

  localparam int DVD_W = tws_pkg::DVD_W;
  localparam int H_W   = tws_pkg::H_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             done_r;
  logic             done_nxt;
  logic [DVD_W-1:0] quo_r;     // dividend shifts out, quotient shifts in
  logic [H_W-1:0]   rem_r;
  logic [H_W-1:0]   dsr_r;
  logic [H_W:0]     shifted;
  logic [H_W:0]     diff;
  logic             qbit;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign qbit    = ~diff[H_W];

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (cnt_r != '0) begin
      // restore when the trial subtract goes negative
      rem_r <= qbit ? diff[H_W-1:0] : shifted[H_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], qbit};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/trapezoid_wall_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_wall_span_generator: wall edge pair to trapezoid fill commands
// Emits one box word, then, unless the wall has no spans, mirrored span words from a slope accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the in_ fields and pulse start while busy is low;
//   the word is taken at that edge and busy rises for the whole wall.
//   Result channel: each command word appears for one cycle with out_strobe
//   high; out_last_command marks the final word of a wall. The receiver
//   must take every word, there is no back pressure.
//   Timing: the box word is registered from the BOX state that follows the
//   accept edge. A wall with no spans returns from that state straight to
//   idle. Otherwise a serial divider forms the slope, one quotient bit per
//   cycle, and the spans follow one per cycle, N spans for a wall (N <= 50
//   by default).
//   Configuration: mono_mode sits at byte address 0 of the APB port; write
//   it only while busy is low. Reset clears mono_mode and the sequencer.
// ----------------------------------------------------------------------------
module trapezoid_wall_span_generator #(
  parameter int HORIZON_ROW = 50,
  parameter int VIEW_WIDTH  = 160
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tws_pkg::ADDR_W-1:0]         paddr,
  input  logic [tws_pkg::DATA_W-1:0]         pwdata,
  output logic [tws_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tws_pkg::X_W-1:0]     in_near_x,
  input  logic [tws_pkg::H_W-1:0]            in_near_height,
  input  logic signed [tws_pkg::X_W-1:0]     in_far_x,
  input  logic [tws_pkg::H_W-1:0]            in_far_height,
  input  logic [tws_pkg::COL_W-1:0]          in_wall_color,
  // result channel
  output logic                               out_strobe,
  output logic                               out_command_kind,
  output logic signed [tws_pkg::X_W-1:0]     out_x_from,
  output logic signed [tws_pkg::XTO_W-1:0]   out_x_to,
  output logic [tws_pkg::ROW_W-1:0]          out_row_above,
  output logic [tws_pkg::ROW_W-1:0]          out_row_below,
  output logic [tws_pkg::COL_W-1:0]          out_fill_color,
  output logic                               out_last_command
);

  localparam int X_W     = tws_pkg::X_W;
  localparam int H_W     = tws_pkg::H_W;
  localparam int XTO_W   = tws_pkg::XTO_W;
  localparam int ROW_W   = tws_pkg::ROW_W;
  localparam int COL_W   = tws_pkg::COL_W;
  localparam int FRAC_W  = tws_pkg::FRAC_BITS;
  localparam int ACC_W   = tws_pkg::ACC_W;
  localparam int SLOPE_W = tws_pkg::SLOPE_W;
  localparam int HR_W    = $clog2(HORIZON_ROW + 1);
  localparam int RC_W    = (HR_W + 1 > ROW_W) ? HR_W + 1 : ROW_W;

  localparam logic [H_W-1:0]   HR_H    = H_W'(HORIZON_ROW);
  localparam logic [HR_W-1:0]  HR_S    = HR_W'(HORIZON_ROW);
  localparam logic [RC_W-1:0]  HR_R    = RC_W'(HORIZON_ROW);
  localparam logic [X_W-1:0]   VW_X    = X_W'(VIEW_WIDTH);
  localparam logic [X_W-1:0]   VW_XM1  = X_W'(VIEW_WIDTH - 1);
  localparam logic [ACC_W-1:0] ACC_RND = ACC_W'(1) << (FRAC_W - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BOX  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_SPAN = 3'd4;

  logic mono_mode;

  tws_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .mono_mode (mono_mode)
  );

  tws_pkg::div_req_t div_req;
  tws_pkg::div_rsp_t div_rsp;

  tws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Edge preparation at accept
  // --------------------------------------------------------------------------
  logic             accept;
  logic [H_W-1:0]   h0_near;
  logic [H_W-1:0]   h0_far;
  logic             swap;
  logic [H_W-1:0]   ha_pre;
  logic [H_W-1:0]   hb_pre;
  logic [X_W-1:0]   xa_pre;
  logic [X_W-1:0]   xb_pre;
  logic [X_W-1:0]   xa_fix;
  logic [X_W-1:0]   xb_fix;
  logic [HR_W-1:0]  ha_clip;

  assign h0_near = mono_mode ? {1'b0, in_near_height[H_W-1:1]} : in_near_height;
  assign h0_far  = mono_mode ? {1'b0, in_far_height[H_W-1:1]}  : in_far_height;
  assign swap    = (h0_near > h0_far);
  assign ha_pre  = swap ? h0_far  : h0_near;
  assign hb_pre  = swap ? h0_near : h0_far;
  assign xa_pre  = swap ? in_far_x  : in_near_x;
  assign xb_pre  = swap ? in_near_x : in_far_x;
  assign xa_fix  = (xa_pre == VW_X) ? VW_XM1 : xa_pre;
  assign xb_fix  = (xb_pre == VW_X) ? VW_XM1 : xb_pre;
  assign ha_clip = (ha_pre > HR_H) ? HR_S : ha_pre[HR_W-1:0];

  // --------------------------------------------------------------------------
  // Sequencer state and working registers
  // --------------------------------------------------------------------------
  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [X_W-1:0]     xa_r;
  logic [X_W-1:0]     xb_r;
  logic [HR_W-1:0]    ha_r;
  logic [H_W-1:0]     hb_r;
  logic [COL_W-1:0]   col_r;
  logic [HR_W-1:0]    h_r;
  logic [HR_W-1:0]    h_end_r;
  logic               neg_r;
  logic [SLOPE_W-1:0] slope_r;
  logic [ACC_W-1:0]   acc_r;

  logic [H_W-1:0]     ha_ext;
  logic               no_span;
  logic [HR_W-1:0]    h_end;
  logic [X_W:0]       dx;
  logic [X_W:0]       dx_mag;
  logic [SLOPE_W-1:0] quo_ext;
  logic [ACC_W-1:0]   slope_ext;
  logic [ACC_W-1:0]   half_ext;
  logic [ACC_W-1:0]   xa16;
  logic               span_last;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);

  assign ha_ext  = {{(H_W-HR_W){1'b0}}, ha_r};
  assign no_span = (hb_r == ha_ext) || (ha_r == HR_S);
  assign h_end   = (hb_r > HR_H) ? HR_S : hb_r[HR_W-1:0];
  assign dx      = {xb_r[X_W-1], xb_r} - {xa_r[X_W-1], xa_r};
  assign dx_mag  = dx[X_W] ? -dx : dx;

  assign div_req.start    = (state_r == ST_BOX) && !no_span;
  assign div_req.dividend = {dx_mag[X_W-1:0], {FRAC_W{1'b0}}};
  assign div_req.divisor  = hb_r - ha_ext;

  assign quo_ext   = {1'b0, div_rsp.quotient};
  assign slope_ext = {{(ACC_W-SLOPE_W){slope_r[SLOPE_W-1]}}, slope_r};
  // arithmetic half of the slope, rounding toward minus infinity
  assign half_ext  = {{(ACC_W-SLOPE_W+1){slope_r[SLOPE_W-1]}}, slope_r[SLOPE_W-1:1]};
  assign xa16      = {{(ACC_W-X_W-FRAC_W){xa_r[X_W-1]}}, xa_r, {FRAC_W{1'b0}}};
  assign span_last = (h_r == h_end_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_BOX;
      ST_BOX:  state_nxt = no_span ? ST_IDLE : ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_SPAN;
      ST_SPAN: if (span_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xa_r  <= xa_fix;
      xb_r  <= xb_fix;
      ha_r  <= ha_clip;
      hb_r  <= hb_pre;
      col_r <= in_wall_color;
    end
    if (state_r == ST_BOX) begin
      neg_r   <= dx[X_W];
      h_end_r <= h_end;
    end
    if ((state_r == ST_DIV) && div_rsp.done) begin
      slope_r <= neg_r ? -quo_ext : quo_ext;
    end
    if (state_r == ST_INIT) begin
      acc_r <= xa16 + half_ext + ACC_RND;
      h_r   <= ha_r + 1'b1;
    end else if (state_r == ST_SPAN) begin
      acc_r <= acc_r + slope_ext;
      h_r   <= h_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result word register
  // --------------------------------------------------------------------------
  logic               strobe_r;
  logic               strobe_nxt;
  logic               kind_r;
  logic [X_W-1:0]     xfrom_r;
  logic [XTO_W-1:0]   xto_r;
  logic [ROW_W-1:0]   ra_r;
  logic [ROW_W-1:0]   rb_r;
  logic [COL_W-1:0]   fcol_r;
  logic               last_r;
  logic               is_box;
  logic [HR_W-1:0]    h_sel;
  logic [RC_W-1:0]    row_up;
  logic [RC_W-1:0]    row_dn;

  assign is_box     = (state_r == ST_BOX);
  assign strobe_nxt = is_box || (state_r == ST_SPAN);
  assign h_sel      = is_box ? ha_r : h_r;
  assign row_up     = HR_R - {{(RC_W-HR_W){1'b0}}, h_sel};
  assign row_dn     = HR_R + {{(RC_W-HR_W){1'b0}}, h_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (strobe_nxt) begin
      kind_r  <= is_box ? tws_pkg::CMD_BOX : tws_pkg::CMD_SPAN;
      xfrom_r <= is_box ? xa_r : xb_r;
      xto_r   <= is_box ? {{(XTO_W-X_W){xb_r[X_W-1]}}, xb_r} : acc_r[ACC_W-1:FRAC_W];
      ra_r    <= row_up[ROW_W-1:0];
      rb_r    <= row_dn[ROW_W-1:0];
      fcol_r  <= col_r;
      last_r  <= is_box ? no_span : span_last;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_command_kind = kind_r;
  assign out_x_from       = xfrom_r;
  assign out_x_to         = xto_r;
  assign out_row_above    = ra_r;
  assign out_row_below    = rb_r;
  assign out_fill_color   = fcol_r;
  assign out_last_command = last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without a wall in progress");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the slope step");

  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPAN) |-> (h_r <= h_end_r))
    else $error("span row ran past its end");

  a_span_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_command_kind == tws_pkg::CMD_SPAN)) |->
      (ROW_W'(out_row_above + out_row_below) == ROW_W'(2 * HORIZON_ROW)))
    else $error("span rows not mirrored about the horizon");

endmodule
